/* hdl/pgw_pkg.sv */
// Shared constants, types and entry helpers for the page table map walker.
package pgw_pkg;

  // Field widths fixed by the entry and request formats.
  localparam int ENTRY_W   = 64;
  localparam int FRAME_W   = 40;
  localparam int VPAGE_W   = 36;
  localparam int IDX_W     = 9;
  localparam int LEVEL_W   = 2;
  localparam int STATUS_W  = 2;
  localparam int CREATED_W = 2;

  // Default number of 4 KiB table frames in the local store.
  localparam int TABLE_FRAMES_DEF = 16;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_MAPPED   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_FRAME = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_PTR  = 2'd2;

  // Level of the leaf table.
  localparam logic [LEVEL_W-1:0] LEAF_LEVEL = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                clr_wr;     // reset clearing pass: zero one store entry
    logic                load;       // capture a new request
    logic                descend;    // follow a present pointer entry
    logic                alloc;      // take the next free frame
    logic                zero_wr;    // zero one entry of the new frame
    logic                link_wr;    // write the pointer to the new frame
    logic                leaf_wr;    // write the leaf entry
    logic                finish;     // latch the result status
    logic [STATUS_W-1:0] fin_status;
  } pgw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic present;      // present bit of the entry just read
    logic ptr_ok;       // pointer of that entry lies inside the store
    logic frame_avail;  // a free frame is left
    logic leaf_level;   // current level is the leaf table
    logic clr_last;     // last entry of the reset clearing pass
    logic zero_last;    // last entry of a new frame
  } pgw_sts_t;

  // Point an entry at a frame, set present and writable, keep the other bits.
  function automatic logic [ENTRY_W-1:0] point_entry(input logic [ENTRY_W-1:0] old,
                                                     input logic [FRAME_W-1:0] frame);
    point_entry = {old[ENTRY_W-1:52], frame, old[11:2], 2'b11};
  endfunction

endpackage

/* hdl/page_table_map_walker.sv */
// Top level of the four-level page table map walker.
//
//   channel  ports                                            handshake
//   request  in_virtual_page, in_physical_frame              start & !busy
//   result   out_status, out_tables_created                   out_valid, one cycle
//   config   cfg_table_base_frame                             cfg_valid & cfg_ready
//
// A request with no missing level passes through a read state and a check state per
// level on the single store port, then the registered result strobe; the next
// request is taken at the edge that ends the strobe cycle. Each allocated table adds
// the zeroing of every entry of the new frame and one link write before the next
// level is read. After reset the store is cleared one entry per cycle with busy high;
// configuration writes are taken at any time. The result is shown for one cycle and
// cannot be held off.
module page_table_map_walker
  import pgw_pkg::*;
#(
  parameter int TABLE_FRAMES = TABLE_FRAMES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [VPAGE_W-1:0]   in_virtual_page,
  input  logic [FRAME_W-1:0]   in_physical_frame,
  output logic                 out_valid,
  output logic [STATUS_W-1:0]  out_status,
  output logic [CREATED_W-1:0] out_tables_created,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [FRAME_W-1:0]   cfg_table_base_frame
);

  pgw_cmd_t cmd;
  pgw_sts_t sts;

  // The base frame register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  pgw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (out_valid),
    .cmd   (cmd),
    .sts   (sts)
  );

  pgw_datapath #(
    .TABLE_FRAMES (TABLE_FRAMES)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_base    (cfg_table_base_frame),
    .req_vpage   (in_virtual_page),
    .req_pframe  (in_physical_frame),
    .res_status  (out_status),
    .res_created (out_tables_created)
  );

endmodule

/* hdl/pgw_ram.sv */
// Generic single-port RAM with registered read data.
module pgw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write when enabled; the read data is registered and comes in the cycle after the address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/pgw_datapath.sv */
// Datapath of the walker: request registers, allocator, counters and the table store.
module pgw_datapath
  import pgw_pkg::*;
#(
  parameter int TABLE_FRAMES = TABLE_FRAMES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pgw_cmd_t              cmd,
  output pgw_sts_t              sts,
  input  logic                  cfg_we,
  input  logic [FRAME_W-1:0]    cfg_base,
  input  logic [VPAGE_W-1:0]    req_vpage,
  input  logic [FRAME_W-1:0]    req_pframe,
  output logic [STATUS_W-1:0]   res_status,
  output logic [CREATED_W-1:0]  res_created
);

  localparam int DEPTH = TABLE_FRAMES * (2 ** IDX_W);
  localparam int AW    = $clog2(DEPTH);
  localparam int FIW   = $clog2(TABLE_FRAMES);
  localparam int NFW   = $clog2(TABLE_FRAMES + 1);

  logic [FRAME_W-1:0]   base_r;
  logic [VPAGE_W-1:0]   vpage_r;
  logic [FRAME_W-1:0]   pframe_r;
  logic [LEVEL_W-1:0]   level_r;
  logic [FIW-1:0]       table_r;
  logic [FIW-1:0]       alloc_r;
  logic [NFW-1:0]       next_free_r;
  logic [CREATED_W-1:0] created_r;
  logic [ENTRY_W-1:0]   entry_r;
  logic [AW-1:0]        cnt_r;
  logic [STATUS_W-1:0]  status_r;

  logic [IDX_W-1:0]     idx;
  logic [FRAME_W-1:0]   ptr_frame;
  logic                 we;
  logic [AW-1:0]        addr;
  logic [ENTRY_W-1:0]   wdata;
  logic [ENTRY_W-1:0]   rdata;

  // Table index of the current level.
  always_comb begin
    case (level_r)
      2'd0:    idx = vpage_r[4*IDX_W-1:3*IDX_W];
      2'd1:    idx = vpage_r[3*IDX_W-1:2*IDX_W];
      2'd2:    idx = vpage_r[2*IDX_W-1:IDX_W];
      default: idx = vpage_r[IDX_W-1:0];
    endcase
  end

  // Store frame that a read entry points to, relative to the root frame.
  assign ptr_frame = rdata[FRAME_W+11:12] - base_r;

  // Store port: clearing, zeroing of a new frame, or the walk slot.
  always_comb begin
    if (cmd.clr_wr) begin
      addr = cnt_r;
    end else if (cmd.zero_wr) begin
      addr = {alloc_r, cnt_r[IDX_W-1:0]};
    end else begin
      addr = {table_r, idx};
    end
    we = cmd.clr_wr | cmd.zero_wr | cmd.link_wr | cmd.leaf_wr;
    if (cmd.link_wr) begin
      wdata = point_entry(entry_r, base_r + FRAME_W'(alloc_r));
    end else if (cmd.leaf_wr) begin
      wdata = point_entry(rdata, pframe_r);
    end else begin
      wdata = '0;
    end
  end

  pgw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  // Status toward the controller.
  always_comb begin
    sts.present     = rdata[0];
    sts.ptr_ok      = ptr_frame < FRAME_W'(TABLE_FRAMES);
    sts.frame_avail = next_free_r < NFW'(TABLE_FRAMES);
    sts.leaf_level  = level_r == LEAF_LEVEL;
    sts.clr_last    = cnt_r == AW'(DEPTH - 1);
    sts.zero_last   = &cnt_r[IDX_W-1:0];
  end

  // Control registers: base frame, allocator, counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      next_free_r <= NFW'(1);
      created_r   <= '0;
      level_r     <= '0;
      cnt_r       <= '0;
    end else begin
      if (cfg_we) begin
        base_r <= cfg_base;
      end
      if (cmd.load) begin
        created_r <= '0;
        level_r   <= '0;
      end
      if (cmd.descend || cmd.link_wr) begin
        level_r <= level_r + LEVEL_W'(1);
      end
      if (cmd.alloc) begin
        next_free_r <= next_free_r + NFW'(1);
        created_r   <= created_r + CREATED_W'(1);
        cnt_r       <= '0;
      end else if (cmd.clr_wr || cmd.zero_wr) begin
        cnt_r <= cnt_r + AW'(1);
      end
    end
  end

  // Payload registers of the walk.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vpage_r  <= req_vpage;
      pframe_r <= req_pframe;
      table_r  <= '0;
    end else if (cmd.descend) begin
      table_r <= ptr_frame[FIW-1:0];
    end else if (cmd.link_wr) begin
      table_r <= alloc_r;
    end
    if (cmd.alloc) begin
      alloc_r <= next_free_r[FIW-1:0];
      entry_r <= rdata;
    end
    if (cmd.finish) begin
      status_r <= cmd.fin_status;
    end
  end

  assign res_status  = status_r;
  assign res_created = created_r;

endmodule

/* hdl/pgw_ctrl.sv */
// Controller state machine of the walker.
module pgw_ctrl
  import pgw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     done,
  output pgw_cmd_t cmd,
  input  pgw_sts_t sts
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_ZERO,
    S_LINK
  } state_t;

  state_t state_r, state_nxt;
  logic   done_r, done_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.leaf_level) begin
          cmd.leaf_wr    = 1'b1;
          cmd.finish     = 1'b1;
          cmd.fin_status = STAT_MAPPED;
          done_nxt       = 1'b1;
          state_nxt      = S_IDLE;
        end else if (sts.present) begin
          if (sts.ptr_ok) begin
            cmd.descend = 1'b1;
            state_nxt   = S_READ;
          end else begin
            cmd.finish     = 1'b1;
            cmd.fin_status = STAT_BAD_PTR;
            done_nxt       = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else if (sts.frame_avail) begin
          cmd.alloc = 1'b1;
          state_nxt = S_ZERO;
        end else begin
          cmd.finish     = 1'b1;
          cmd.fin_status = STAT_NO_FRAME;
          done_nxt       = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_ZERO: begin
        cmd.zero_wr = 1'b1;
        if (sts.zero_last) begin
          state_nxt = S_LINK;
        end
      end
      S_LINK: begin
        cmd.link_wr = 1'b1;
        state_nxt   = S_READ;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and the registered result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  assign busy = state_r != S_IDLE;
  assign done = done_r;

endmodule
